// ===== sv/sha512_pkg.sv =====
// Types, constants and round functions for the SHA-512 hash core.
`default_nettype none
package sha512_pkg;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  valid_bytes;
        logic        last;
    } sha512_in_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } sha512_out_t;

    localparam int unsigned WordW     = 64;
    localparam int unsigned SchedD    = 16;
    localparam int unsigned RoundsN   = 80;
    localparam int unsigned HashN     = 8;
    localparam int unsigned LenWordIx = 14;

    localparam logic [63:0] IV [0:7] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] K [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] bsig0(input logic [63:0] x);
        bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic logic [63:0] bsig1(input logic [63:0] x);
        bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic logic [63:0] ssig0(input logic [63:0] x);
        ssig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] ssig1(input logic [63:0] x);
        ssig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

endpackage
`default_nettype wire

// ===== sv/sha512_hash_core.sv =====
// SHA-512 hash core: word intake, padding sequencer, shared round unit.
//
// Input channel (in_valid/in_ready, payload in_data) takes one 64-bit
// big-endian message word with a byte count and a last flag. Output channel
// (out_valid/out_ready, payload out_data) gives the eight digest words, index
// 0 first, digest_last on the eighth.
// A word that is neither last nor closes a 128-byte block is stored and the
// core stays ready for the next word. The sixteenth word of a block starts
// the round unit: 80 rounds at one per cycle, then a fold step that adds the
// working words into the hash. A last word is followed by the padding words
// (one per cycle), one or two block compressions, then eight digest words,
// one per cycle the receiver takes them. in_ready stays low from a last word
// until the eighth digest word is taken, held there by a stalled receiver.
// Reset loads the initial hash values and clears the byte count; the
// schedule window needs no clearing since each entry is written before use.
`default_nettype none
module sha512_hash_core
    import sha512_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire sha512_in_t  in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output sha512_out_t      out_data
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROUND, ST_FOLD, ST_PAD, ST_OUT
    } state_t;

    state_t       state_reg;
    logic [63:0]  h_reg [0:7];
    logic [63:0]  v_reg [0:7];
    logic [63:0]  w_reg [0:15];
    logic [3:0]   wib_reg;
    logic [6:0]   round_reg;
    logic [63:0]  len_reg;
    logic         padding_reg;   // in padding phase of a message
    logic         extra_reg;     // leading 0x80 word still owed (full last word)
    logic [2:0]   oidx_reg;
    logic         len_slot_reg;  // slot 14 got a plain zero pad, so slot 15 takes the length

    // Shared round datapath
    logic [3:0]   ti;
    logic [63:0]  w_cur, t1, t2;
    always_comb
    begin
        ti = round_reg[3:0];
        if (round_reg < 7'(SchedD))
            w_cur = w_reg[ti];
        else
            w_cur = ssig1(w_reg[ti - 4'd2]) + w_reg[ti - 4'd7]
                  + ssig0(w_reg[ti - 4'd15]) + w_reg[ti];
        t1 = v_reg[7] + bsig1(v_reg[4]) + (v_reg[6] ^ (v_reg[4] & (v_reg[5] ^ v_reg[6])))
           + K[round_reg] + w_cur;
        t2 = bsig0(v_reg[0]) + ((v_reg[0] & v_reg[1]) | (v_reg[0] & v_reg[2])
           | (v_reg[1] & v_reg[2]));
    end

    // Intake word shaping
    logic [3:0]  cnt;
    logic [63:0] keep, masked;
    logic [5:0]  shamt;
    always_comb
    begin
        cnt   = (in_data.valid_bytes > 4'd8) ? 4'd8 : in_data.valid_bytes;
        shamt = 6'(8 * (8 - cnt));
        keep  = (cnt == 4'd0) ? 64'd0 : (~64'd0 << shamt);
        masked = (in_data.message_word & keep)
               | ((cnt == 4'd8) ? 64'd0 : (64'h80 << (shamt - 6'd8)));
    end

    // Pad word for the current slot
    logic [63:0] pad_word;
    always_comb
    begin
        if (extra_reg)
            pad_word = 64'h80 << 56;
        else if (wib_reg == 4'd15 && len_slot_reg)
            pad_word = len_reg << 3;
        else
            pad_word = 64'd0;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    always_comb
    begin
        out_data.digest_word = h_reg[oidx_reg];
        out_data.word_index  = oidx_reg;
        out_data.digest_last = (oidx_reg == 3'd7);
    end

    logic in_fire;
    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wib_reg     <= '0;
            round_reg   <= '0;
            len_reg     <= '0;
            padding_reg <= 1'b0;
            extra_reg   <= 1'b0;
            oidx_reg    <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= IV[i];
                v_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        w_reg[wib_reg] <= in_data.last ? masked : in_data.message_word;
                        wib_reg <= wib_reg + 4'd1;
                        len_reg <= len_reg + (in_data.last ? 64'(cnt) : 64'd8);
                        padding_reg <= in_data.last;
                        extra_reg   <= in_data.last && (cnt == 4'd8);
                        if (wib_reg == 4'd15)
                        begin
                            state_reg <= ST_ROUND;
                            for (int i = 0; i < 8; i++)
                                v_reg[i] <= h_reg[i];
                        end
                        else if (in_data.last)
                            state_reg <= ST_PAD;
                    end
                end
                ST_PAD:
                begin
                    // push one pad word per cycle until the block is full
                    w_reg[wib_reg] <= pad_word;
                    extra_reg <= 1'b0;
                    wib_reg <= wib_reg + 4'd1;
                    if (wib_reg == 4'd15)
                    begin
                        state_reg <= ST_ROUND;
                        for (int i = 0; i < 8; i++)
                            v_reg[i] <= h_reg[i];
                    end
                end
                ST_ROUND:
                begin
                    if (round_reg >= 7'(SchedD))
                        w_reg[ti] <= w_cur;
                    for (int i = 7; i > 0; i--)
                        v_reg[i] <= v_reg[i-1];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[0] <= t1 + t2;
                    if (round_reg == 7'(RoundsN - 1))
                    begin
                        round_reg <= '0;
                        state_reg <= ST_FOLD;
                    end
                    else
                        round_reg <= round_reg + 7'd1;
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    if (!padding_reg)
                        state_reg <= ST_IDLE;
                    else if (!len_slot_reg)
                        state_reg <= ST_PAD;
                    else
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            state_reg   <= ST_IDLE;
                            padding_reg <= 1'b0;
                            len_reg     <= '0;
                            wib_reg     <= '0;
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= IV[i];
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // The length fits only in a block whose slot 14 is a zero pad word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_slot_reg <= 1'b0;
        else if (state_reg == ST_PAD && wib_reg == 4'd14)
            len_slot_reg <= !extra_reg;
        else if (state_reg == ST_OUT)
            len_slot_reg <= 1'b0;
    end

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready and valid together");
    a_last_ix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.digest_last |-> out_data.word_index == 3'd7)
        else $error("digest_last off position");
    a_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND && round_reg == 7'd79 |=> state_reg == ST_FOLD)
        else $error("round count overran");

endmodule
`default_nettype wire
